// ----- sv/mctcs_pkg.sv -----
// shared constants, cue and note tables, and transaction types for the tone cue sequencer
// no dependencies; every other file refers to it by scoped names
package mctcs_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int CUE_COUNT    = 23;
    localparam int TIME_BITS    = 32;
    localparam int ROM_CUES     = 23;
    localparam int ROM_NOTES    = 45;
    localparam int QUEUE_DEPTH  = 2;

    localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int CUE_W    = 5;
    localparam int POS_W    = 3;
    localparam int IDX_W    = 6;
    localparam int LEN_W    = 3;
    localparam int FREQ_W   = 12;
    localparam int MS_W     = 8;
    localparam int GAP_W    = 4;
    localparam int OUT_CH_W = 2;
    localparam int RAW_W    = 8;

    localparam logic [CUE_W-1:0]  ERROR_CUE    = 5'd13;
    localparam logic [CUE_W-1:0]  MUTE_OFF_CUE = 5'd19;
    localparam logic [FREQ_W-1:0] CLICK_FREQ   = 12'd220;
    localparam logic [MS_W-1:0]   CLICK_MS     = 8'd35;

    // command codes, equal to the input kind codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_PLAY   = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_TOGGLE = 2'd3;

    localparam logic [FREQ_W-1:0] NOTE_FREQ [ROM_NOTES] = '{
        12'd1760, 12'd1320, 12'd1760, 12'd740,  12'd440,  12'd880,  12'd1175, 12'd1568,
        12'd1047, 12'd784,  12'd988,  12'd740,  12'd1175, 12'd220,  12'd1976, 12'd1568,
        12'd523,  12'd392,  12'd1175, 12'd1568, 12'd784,  12'd1047, 12'd1568, 12'd392,
        12'd294,  12'd196,  12'd147,  12'd1568, 12'd2093, 12'd659,  12'd880,  12'd1175,
        12'd330,  12'd220,  12'd220,  12'd440,  12'd1047, 12'd1319, 12'd1568, 12'd784,
        12'd988,  12'd1319, 12'd1976, 12'd1319, 12'd1760};

    localparam logic [MS_W-1:0] NOTE_DUR [ROM_NOTES] = '{
        8'd18,  8'd24,  8'd30,  8'd35,  8'd45,  8'd35,  8'd35,  8'd55,  8'd35,  8'd45,
        8'd22,  8'd24,  8'd34,  8'd30,  8'd20,  8'd20,  8'd28,  8'd42,  8'd26,  8'd34,
        8'd45,  8'd45,  8'd75,  8'd55,  8'd70,  8'd45,  8'd45,  8'd50,  8'd70,  8'd150,
        8'd150, 8'd150, 8'd25,  8'd35,  8'd25,  8'd35,  8'd26,  8'd26,  8'd38,  8'd30,
        8'd30,  8'd30,  8'd60,  8'd18,  8'd26};

    localparam logic [GAP_W-1:0] NOTE_GAP [ROM_NOTES] = '{
        4'd0, 4'd8, 4'd0, 4'd8, 4'd0, 4'd8, 4'd8, 4'd0, 4'd8, 4'd0,
        4'd0, 4'd6, 4'd0, 4'd0, 4'd5, 4'd0, 4'd6, 4'd0, 4'd6, 4'd0,
        4'd8, 4'd8, 4'd0, 4'd8, 4'd0, 4'd8, 4'd0, 4'd6, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd5, 4'd0, 4'd5, 4'd0, 4'd4, 4'd4, 4'd0, 4'd6,
        4'd6, 4'd6, 4'd0, 4'd4, 4'd0};

    localparam logic [IDX_W-1:0] CUE_START [ROM_CUES] = '{
        6'd0,  6'd1,  6'd3,  6'd5,  6'd8,  6'd10, 6'd11, 6'd13, 6'd14, 6'd16, 6'd18, 6'd20,
        6'd23, 6'd25, 6'd27, 6'd29, 6'd30, 6'd31, 6'd32, 6'd34, 6'd36, 6'd39, 6'd43};

    localparam logic [LEN_W-1:0] CUE_LEN [ROM_CUES] = '{
        3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3,
        3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd2};

    localparam logic [1:0] CUE_CHAN [ROM_CUES] = '{
        2'd0, 2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2,
        2'd2, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd1};

    // decoded command handed from front to back
    typedef struct packed {
        logic [1:0]           op;
        logic [CUE_W-1:0]     cue;
        logic [CH_W-1:0]      ch;
        logic                 mute_off_cue;
        logic                 mute_value;
        logic [TIME_BITS-1:0] now;
    } cmd_t;

    // one result transaction
    typedef struct packed {
        logic              last;
        logic              muted;
        logic              stop_all;
        logic [OUT_CH_W-1:0] ch;
        logic [MS_W-1:0]   ms;
        logic [FREQ_W-1:0] freq;
    } res_t;

endpackage

// ----- sv/mctcs_front.sv -----
// front end: accepts input transactions and decodes them into commands
// depends on mctcs_pkg
module mctcs_front
(
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [47:0]       s_axis_tdata,   // now_ms, cue, mute_value
    input  logic [1:0]        s_axis_tuser,   // kind
    input  logic              queue_full,
    output logic              push,
    output mctcs_pkg::cmd_t   cmd
);

    localparam int TIME_BITS = mctcs_pkg::TIME_BITS;
    localparam int CH_W      = mctcs_pkg::CH_W;
    localparam int CUE_W     = mctcs_pkg::CUE_W;
    localparam int RAW_W     = mctcs_pkg::RAW_W;

    logic [RAW_W-1:0] raw_cue;
    logic [CUE_W-1:0] cue_res;
    logic [1:0]       cue_ch;
    logic             drop;

    assign raw_cue = s_axis_tdata[39:32];

    always_comb
    begin
        if (int'(raw_cue) >= mctcs_pkg::CUE_COUNT || int'(raw_cue) >= mctcs_pkg::ROM_CUES)
        begin
            cue_res = mctcs_pkg::ERROR_CUE;
        end
        else
        begin
            cue_res = raw_cue[CUE_W-1:0];
        end
        cue_ch = mctcs_pkg::CUE_CHAN[cue_res];
    end

    always_comb
    begin
        cmd.op           = s_axis_tuser;
        cmd.cue          = cue_res;
        cmd.ch           = CH_W'(cue_ch);
        cmd.mute_off_cue = (raw_cue == {3'b000, mctcs_pkg::MUTE_OFF_CUE});
        cmd.mute_value   = s_axis_tdata[40];
        cmd.now          = s_axis_tdata[TIME_BITS-1:0];
        // a play whose cue sits on a missing channel does nothing
        drop             = (s_axis_tuser == mctcs_pkg::OP_PLAY)
                           && (int'(cue_ch) >= mctcs_pkg::NUM_CHANNELS);
    end

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full && !drop;

endmodule

// ----- sv/mctcs_queue.sv -----
// short command queue between front end and sequencer
// depends on mctcs_pkg
module mctcs_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mctcs_pkg::cmd_t push_cmd,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop,
    output mctcs_pkg::cmd_t pop_cmd
);

    localparam int DEPTH = mctcs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = mctcs_pkg::PTR_W;
    localparam int CNT_W = mctcs_pkg::CNT_W;

    mctcs_pkg::cmd_t  q_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/mctcs_back.sv -----
// back end: channel state, note sequencing and the result register
// depends on mctcs_pkg
module mctcs_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_pop,
    input  mctcs_pkg::cmd_t cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output mctcs_pkg::res_t res
);

    localparam int NCH       = mctcs_pkg::NUM_CHANNELS;
    localparam int CH_W      = mctcs_pkg::CH_W;
    localparam int TIME_BITS = mctcs_pkg::TIME_BITS;
    localparam int CUE_W     = mctcs_pkg::CUE_W;
    localparam int POS_W     = mctcs_pkg::POS_W;
    localparam int IDX_W     = mctcs_pkg::IDX_W;
    localparam int OUT_CH_W  = mctcs_pkg::OUT_CH_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_CLICK = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [NCH-1:0]       mask_reg, mask_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 mute_reg, mute_next;
    logic [NCH-1:0]       active_reg, active_next;
    logic [CUE_W-1:0]     cue_reg [NCH];
    logic [CUE_W-1:0]     cue_next [NCH];
    logic [POS_W-1:0]     pos_reg [NCH];
    logic [POS_W-1:0]     pos_next [NCH];
    logic [TIME_BITS-1:0] due_reg [NCH];
    logic [TIME_BITS-1:0] due_next [NCH];
    logic                 out_valid_reg, out_valid_next;
    mctcs_pkg::res_t      out_reg, out_next;

    logic [TIME_BITS-1:0] tdiff [NCH];
    logic [NCH-1:0]       due_mask;
    logic [CH_W-1:0]      run_ch;
    logic [NCH-1:0]       rem_mask;
    logic [CUE_W-1:0]     run_cue;
    logic [POS_W-1:0]     run_pos;
    logic [POS_W-1:0]     pos_inc;
    logic [IDX_W-1:0]     note_idx;
    logic [TIME_BITS-1:0] due_new;
    logic                 out_free;
    logic                 target;

    // channels due on a tick, signed wrap compare
    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            tdiff[i]    = cmd.now - due_reg[i];
            due_mask[i] = active_reg[i] && !tdiff[i][TIME_BITS-1];
        end
    end

    // lowest pending channel and its next note
    always_comb
    begin
        run_ch = '0;
        for (int i = NCH - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                run_ch = CH_W'(i);
            end
        end
        rem_mask = mask_reg & ~(NCH'(1) << run_ch);
        run_cue  = cue_reg[run_ch];
        run_pos  = pos_reg[run_ch];
        pos_inc  = run_pos + 1'b1;
        note_idx = mctcs_pkg::CUE_START[run_cue] + IDX_W'(run_pos);
        due_new  = now_reg + TIME_BITS'(mctcs_pkg::NOTE_DUR[note_idx])
                   + TIME_BITS'(mctcs_pkg::NOTE_GAP[note_idx]);
    end

    assign out_free = !out_valid_reg || res_ready;

    always_comb
    begin
        state_next     = state_reg;
        mask_next      = mask_reg;
        now_next       = now_reg;
        mute_next      = mute_reg;
        active_next    = active_reg;
        cue_next       = cue_reg;
        pos_next       = pos_reg;
        due_next       = due_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        target         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    now_next = cmd.now;
                    case (cmd.op)
                        mctcs_pkg::OP_TICK:
                        begin
                            if (!mute_reg && due_mask != '0)
                            begin
                                mask_next  = due_mask;
                                state_next = ST_RUN;
                            end
                        end
                        mctcs_pkg::OP_PLAY:
                        begin
                            if (!mute_reg || cmd.mute_off_cue)
                            begin
                                active_next[cmd.ch] = 1'b1;
                                cue_next[cmd.ch]    = cmd.cue;
                                pos_next[cmd.ch]    = '0;
                                due_next[cmd.ch]    = cmd.now;
                                mask_next           = NCH'(1) << cmd.ch;
                                state_next          = ST_RUN;
                            end
                        end
                        default:
                        begin
                            target = (cmd.op == mctcs_pkg::OP_SET) ? cmd.mute_value : !mute_reg;
                            if (target != mute_reg)
                            begin
                                mute_next = target;
                                if (target)
                                begin
                                    // mute entry clears every channel
                                    active_next = '0;
                                    for (int i = 0; i < NCH; i++)
                                    begin
                                        cue_next[i] = '0;
                                        pos_next[i] = '0;
                                        due_next[i] = '0;
                                    end
                                    state_next = ST_CLICK;
                                end
                                else
                                begin
                                    active_next[CH_W'(mctcs_pkg::CUE_CHAN[mctcs_pkg::MUTE_OFF_CUE])]
                                        = 1'b1;
                                    cue_next[CH_W'(mctcs_pkg::CUE_CHAN[mctcs_pkg::MUTE_OFF_CUE])]
                                        = mctcs_pkg::MUTE_OFF_CUE;
                                    pos_next[CH_W'(mctcs_pkg::CUE_CHAN[mctcs_pkg::MUTE_OFF_CUE])]
                                        = '0;
                                    due_next[CH_W'(mctcs_pkg::CUE_CHAN[mctcs_pkg::MUTE_OFF_CUE])]
                                        = cmd.now;
                                    mask_next = NCH'(1)
                                        << mctcs_pkg::CUE_CHAN[mctcs_pkg::MUTE_OFF_CUE];
                                    state_next = ST_RUN;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.freq         = mctcs_pkg::NOTE_FREQ[note_idx];
                    out_next.ms           = mctcs_pkg::NOTE_DUR[note_idx];
                    out_next.ch           = OUT_CH_W'(run_ch);
                    out_next.stop_all     = 1'b0;
                    out_next.muted        = mute_reg;
                    out_next.last         = (rem_mask == '0);
                    pos_next[run_ch]      = pos_inc;
                    due_next[run_ch]      = due_new;
                    if (pos_inc >= mctcs_pkg::CUE_LEN[run_cue])
                    begin
                        active_next[run_ch] = 1'b0;
                    end
                    mask_next = rem_mask;
                    if (rem_mask == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLICK:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.freq     = mctcs_pkg::CLICK_FREQ;
                    out_next.ms       = mctcs_pkg::CLICK_MS;
                    out_next.ch       = '0;
                    out_next.stop_all = 1'b1;
                    out_next.muted    = 1'b1;
                    out_next.last     = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '0;
            mute_reg      <= 1'b0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCH; i++)
            begin
                cue_reg[i] <= '0;
                pos_reg[i] <= '0;
                due_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            mute_reg      <= mute_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            cue_reg       <= cue_next;
            pos_reg       <= pos_next;
            due_reg       <= due_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> mask_reg != '0)
        else $error("sequencer running with no pending channel");

    a_run_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> (mask_reg & ~active_reg) == '0)
        else $error("pending channel is not active");

    a_click_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.stop_all |-> out_reg.muted && out_reg.last)
        else $error("mute click without muted or last");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.last |-> state_reg == ST_RUN)
        else $error("non-last result but no further result pending");

endmodule

// ----- sv/multi_channel_tone_cue_sequencer.sv -----
// top level of the three-channel tone cue sequencer
// depends on mctcs_pkg, mctcs_front, mctcs_queue and mctcs_back
//
// usage:
//   the s_axis channel takes one command transaction per beat: tick (carries the
//   current millisecond time), play cue, set mute or toggle mute. the m_axis
//   channel gives the tones to start, zero to three per command, with tlast on
//   the final tone of a command.
// sequencing:
//   a decoded command enters a two-entry queue; the sequencer pops it from the
//   queue register when idle and writes the first tone into the output register
//   from its run state, so tones reach m_axis through the queue and output
//   registers. the sequencer handles one command at a time and gives its tones
//   one by one through the single sequencer loop over the channels.
//   commands that give no tone (muted tick, repeated mute) leave it idle.
// reset:
//   all channels idle, mute off, queue empty, no tone pending.
// stall:
//   when m_axis_tready is low the tone waits in the output register and the
//   sequencer holds its next tone; the queue keeps taking commands until it
//   fills, then s_axis_tready drops.
module multi_channel_tone_cue_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // now_ms[31:0], cue[39:32], mute_value[40], zero fill
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // tone_freq[11:0], tone_ms[19:12], channel[21:20], zero fill
    output logic [1:0]  m_axis_tuser,   // stop_all[0], muted[1]
    output logic        m_axis_tlast
);

    mctcs_pkg::cmd_t push_cmd;
    mctcs_pkg::cmd_t pop_cmd;
    mctcs_pkg::res_t res;
    logic            push;
    logic            queue_full;
    logic            pop_valid;
    logic            pop;

    // decode of incoming transactions
    mctcs_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    // decouples the front end from the sequencer
    mctcs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_cmd   (pop_cmd)
    );

    // channel state and tone generation
    mctcs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_pop   (pop),
        .cmd       (pop_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // result packing
    assign m_axis_tdata = {2'b00, res.ch, res.ms, res.freq};
    assign m_axis_tuser = {res.muted, res.stop_all};
    assign m_axis_tlast = res.last;

endmodule
